### src/rv32x_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rv32x_pkg;

   // major opcodes
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_JAL    = 7'h6f;

   // funct7 groups
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;

   // funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_MUL  = 3'd0;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_REM  = 3'd6;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BYTE = 3'd0;
   localparam logic [2:0] F3_HALF = 3'd1;
   localparam logic [2:0] F3_WORD = 3'd2;

   // environment call
   localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
   localparam logic [31:0] ECALL_PRINT = 32'd1;
   localparam logic [31:0] ECALL_EXIT  = 32'd10;
   localparam logic [4:0]  REG_A0      = 5'd10;
   localparam logic [4:0]  REG_A1      = 5'd11;
   localparam logic [4:0]  REG_ZERO    = 5'd0;

   // result status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_PRINT     = 3'd1;
   localparam logic [2:0] ST_EXIT      = 3'd2;
   localparam logic [2:0] ST_ILLEGAL   = 3'd3;
   localparam logic [2:0] ST_BAD_ECALL = 3'd4;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd5;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_SLT, ALU_XOR, ALU_OR, ALU_AND,
      ALU_SLL, ALU_SRL, ALU_SRA, ALU_MUL, ALU_MULH, ALU_DIV, ALU_REM
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } alu_res_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_EXEC, S_ADDR, S_LD_RD, S_LD_CAP,
      S_LD_FIX, S_STORE, S_FINISH, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      A_IDLE, A_SER, A_SHF, A_MUL, A_MFIX1, A_MFIX2, A_DPREP, A_DIV, A_DFIX
   } alu_state_type;

endpackage

`default_nettype wire

### src/rv32x_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

// instruction channel
interface rv32x_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   modport source (output valid, output instr_word, input ready);
   modport sink (input valid, input instr_word, output ready);
endinterface

// result channel
interface rv32x_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [31:0]        next_pc;
   logic               wb_valid;
   logic [4:0]         wb_reg;
   logic [31:0]        wb_value;
   logic signed [31:0] print_value;
   modport source (output valid, output status, output next_pc, output wb_valid,
                   output wb_reg, output wb_value, output print_value, input ready);
   modport sink (input valid, input status, input next_pc, input wb_valid,
                 input wb_reg, input wb_value, input print_value, output ready);
endinterface

`default_nettype wire

### src/rv32_subset_instruction_executor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// add, sub, slt and logic take a bit-serial pass through the ALU and mul a serial shift-add pass,
// shifts move one position per step, mulh adds a signed correction of the high word and div and
// rem a magnitude step and a sign fix; branch, jal, lui, ecall and decode faults finish from
// decode, a halted block answers at once, loads read one byte at a time and stores write one
// byte at a time; one item at a time, the next transfer can be taken the cycle after the result
// transfer; synchronous reset clears pc, halt and the register file valid bits, then the clear state zeroes data memory

module rv32_subset_instruction_executor_unit #(
   parameter int MEM_BYTES = 65536
) (
   input wire logic      clock,
   input wire logic      reset,
   rv32x_req_if.sink     req_if,
   rv32x_rsp_if.source   rsp_if
);

   localparam int AW = $clog2(MEM_BYTES);

   rv32x_pkg::state_type state_ff, state_in;
   logic [31:0]   pc_ff, pc_in;
   logic          halted_ff, halted_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0]   rf_vld_ff, rf_vld_in;

   logic [31:0] instr_ff, instr_in;
   logic [2:0]  st_ff, st_in;
   logic [31:0] npc_ff, npc_in;
   logic        wr_ff, wr_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] pv_ff, pv_in;
   logic        mem_ff, mem_in;
   logic [31:0] addr_ff, addr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] sdat_ff, sdat_in;

   // register file, registered read
   logic [31:0] rf_mem [32];
   logic [31:0] rf_q1_ff, rf_q2_ff;
   logic        rf_v1_ff, rf_v2_ff;
   logic        rf_re, rf_we;
   logic [4:0]  rf_ra1, rf_ra2, rf_waddr;

   // data memory, registered read
   logic [7:0]    data_mem [MEM_BYTES];
   logic [7:0]    mem_q_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   rv32x_pkg::alu_ctl_type alu_ctl;
   rv32x_pkg::alu_res_type alu_res;
   logic [31:0] alu_b;

   // decode fields
   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] a_val, b_val, immi, imms, immb, immj, pc4;
   logic        dec_ok;
   rv32x_pkg::alu_op_type dec_op;
   logic [1:0]  last_byte;
   logic [32:0] end_addr;
   logic        halt_now;

   assign opc   = instr_ff[6:0];
   assign rd    = instr_ff[11:7];
   assign f3    = instr_ff[14:12];
   assign f7    = instr_ff[31:25];
   assign a_val = rf_v1_ff ? rf_q1_ff : 32'd0;
   assign b_val = rf_v2_ff ? rf_q2_ff : 32'd0;
   assign immi  = {{20{instr_ff[31]}}, instr_ff[31:20]};
   assign imms  = {{20{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
   assign immb  = {{19{instr_ff[31]}}, instr_ff[31], instr_ff[7], instr_ff[30:25],
                   instr_ff[11:8], 1'b0};
   assign immj  = {{11{instr_ff[31]}}, instr_ff[31], instr_ff[19:12], instr_ff[20],
                   instr_ff[30:21], 1'b0};
   assign pc4   = pc_ff + 32'd4;

   assign last_byte = (f3 == rv32x_pkg::F3_BYTE) ? 2'd0 :
                      (f3 == rv32x_pkg::F3_HALF) ? 2'd1 : 2'd3;
   assign end_addr  = {1'b0, addr_ff} + 33'(last_byte) + 33'd1;
   assign halt_now  = (st_ff != rv32x_pkg::ST_OK) && (st_ff != rv32x_pkg::ST_PRINT);

   // ecall reads a0 and a1
   assign rf_re  = req_if.valid && req_if.ready;
   assign rf_ra1 = (req_if.instr_word[6:0] == rv32x_pkg::OP_SYSTEM) ? rv32x_pkg::REG_A0
                                                                    : req_if.instr_word[19:15];
   assign rf_ra2 = (req_if.instr_word[6:0] == rv32x_pkg::OP_SYSTEM) ? rv32x_pkg::REG_A1
                                                                    : req_if.instr_word[24:20];
   assign rf_waddr = rd;

   // operation select
   always_comb begin
      dec_ok = 1'b1;
      dec_op = rv32x_pkg::ALU_ADD;
      if (opc == rv32x_pkg::OP_REG) begin
         if (f7 == rv32x_pkg::F7_BASE) begin
            case (f3)
               rv32x_pkg::F3_ADD: dec_op = rv32x_pkg::ALU_ADD;
               rv32x_pkg::F3_SLL: dec_op = rv32x_pkg::ALU_SLL;
               rv32x_pkg::F3_SLT: dec_op = rv32x_pkg::ALU_SLT;
               rv32x_pkg::F3_XOR: dec_op = rv32x_pkg::ALU_XOR;
               rv32x_pkg::F3_SRL: dec_op = rv32x_pkg::ALU_SRL;
               rv32x_pkg::F3_OR:  dec_op = rv32x_pkg::ALU_OR;
               rv32x_pkg::F3_AND: dec_op = rv32x_pkg::ALU_AND;
               default:           dec_ok = 1'b0;
            endcase
         end else if (f7 == rv32x_pkg::F7_ALT && f3 == rv32x_pkg::F3_ADD) begin
            dec_op = rv32x_pkg::ALU_SUB;
         end else if (f7 == rv32x_pkg::F7_ALT && f3 == rv32x_pkg::F3_SRL) begin
            dec_op = rv32x_pkg::ALU_SRA;
         end else if (f7 == rv32x_pkg::F7_MULDIV) begin
            case (f3)
               rv32x_pkg::F3_MUL:  dec_op = rv32x_pkg::ALU_MUL;
               rv32x_pkg::F3_MULH: dec_op = rv32x_pkg::ALU_MULH;
               rv32x_pkg::F3_DIV:  dec_op = rv32x_pkg::ALU_DIV;
               rv32x_pkg::F3_REM:  dec_op = rv32x_pkg::ALU_REM;
               default:            dec_ok = 1'b0;
            endcase
         end else begin
            dec_ok = 1'b0;
         end
      end else begin
         case (f3)
            rv32x_pkg::F3_ADD: dec_op = rv32x_pkg::ALU_ADD;
            rv32x_pkg::F3_SLL: begin
               dec_op = rv32x_pkg::ALU_SLL;
               dec_ok = (f7 == rv32x_pkg::F7_BASE);
            end
            rv32x_pkg::F3_SLT: dec_op = rv32x_pkg::ALU_SLT;
            rv32x_pkg::F3_XOR: dec_op = rv32x_pkg::ALU_XOR;
            rv32x_pkg::F3_SRL: begin
               if (f7 == rv32x_pkg::F7_BASE)     dec_op = rv32x_pkg::ALU_SRL;
               else if (f7 == rv32x_pkg::F7_ALT) dec_op = rv32x_pkg::ALU_SRA;
               else                              dec_ok = 1'b0;
            end
            rv32x_pkg::F3_OR:  dec_op = rv32x_pkg::ALU_OR;
            rv32x_pkg::F3_AND: dec_op = rv32x_pkg::ALU_AND;
            default:           dec_ok = 1'b0;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rv32x_pkg::S_CLEAR;
         pc_ff     <= 32'd0;
         halted_ff <= 1'b0;
         clr_ff    <= '0;
         rf_vld_ff <= 32'd0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         clr_ff    <= clr_in;
         rf_vld_ff <= rf_vld_in;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      instr_ff <= instr_in;
      st_ff    <= st_in;
      npc_ff   <= npc_in;
      wr_ff    <= wr_in;
      val_ff   <= val_in;
      pv_ff    <= pv_in;
      mem_ff   <= mem_in;
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      sdat_ff  <= sdat_in;
   end

   // register file ports
   always_ff @(posedge clock) begin
      if (rf_we)
         rf_mem[rf_waddr] <= val_ff;
      if (rf_re) begin
         rf_q1_ff <= rf_mem[rf_ra1];
         rf_q2_ff <= rf_mem[rf_ra2];
         rf_v1_ff <= rf_vld_ff[rf_ra1];
         rf_v2_ff <= rf_vld_ff[rf_ra2];
      end
   end

   // data memory ports
   always_ff @(posedge clock) begin
      if (mem_we)
         data_mem[mem_waddr] <= mem_wdata;
      if (mem_re)
         mem_q_ff <= data_mem[mem_raddr];
   end

   // main sequencer
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      clr_in    = clr_ff;
      rf_vld_in = rf_vld_ff;
      instr_in  = instr_ff;
      st_in     = st_ff;
      npc_in    = npc_ff;
      wr_in     = wr_ff;
      val_in    = val_ff;
      pv_in     = pv_ff;
      mem_in    = mem_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      sdat_in   = sdat_ff;
      rf_we     = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr_ff[AW-1:0] + AW'(cnt_ff);
      mem_raddr = addr_ff[AW-1:0] + AW'(cnt_ff);
      mem_wdata = sdat_ff[7:0];
      alu_ctl.start = 1'b0;
      alu_ctl.op    = dec_op;
      alu_b         = (opc == rv32x_pkg::OP_REG) ? b_val : immi;
      case (state_ff)
         rv32x_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_BYTES - 1))
               state_in = rv32x_pkg::S_IDLE;
         end
         rv32x_pkg::S_IDLE: begin
            if (req_if.valid) begin
               instr_in = req_if.instr_word;
               if (halted_ff) begin
                  st_in    = rv32x_pkg::ST_EXIT;
                  npc_in   = pc_ff;
                  wr_in    = 1'b0;
                  val_in   = 32'd0;
                  pv_in    = 32'd0;
                  state_in = rv32x_pkg::S_FINISH;
               end else begin
                  state_in = rv32x_pkg::S_DECODE;
               end
            end
         end
         rv32x_pkg::S_DECODE: begin
            st_in    = rv32x_pkg::ST_OK;
            npc_in   = pc4;
            wr_in    = 1'b0;
            val_in   = 32'd0;
            pv_in    = 32'd0;
            mem_in   = 1'b0;
            state_in = rv32x_pkg::S_FINISH;
            case (opc)
               rv32x_pkg::OP_REG, rv32x_pkg::OP_IMM: begin
                  wr_in = 1'b1;
                  if (dec_ok) begin
                     alu_ctl.start = 1'b1;
                     state_in      = rv32x_pkg::S_EXEC;
                  end else begin
                     st_in = rv32x_pkg::ST_ILLEGAL;
                  end
               end
               rv32x_pkg::OP_LOAD, rv32x_pkg::OP_STORE: begin
                  wr_in = (opc == rv32x_pkg::OP_LOAD);
                  if (f3 > rv32x_pkg::F3_WORD) begin
                     st_in = rv32x_pkg::ST_ILLEGAL;
                  end else begin
                     alu_ctl.start = 1'b1;
                     alu_ctl.op    = rv32x_pkg::ALU_ADD;
                     alu_b         = (opc == rv32x_pkg::OP_LOAD) ? immi : imms;
                     mem_in        = 1'b1;
                     state_in      = rv32x_pkg::S_EXEC;
                  end
               end
               rv32x_pkg::OP_BRANCH: begin
                  if (f3 > rv32x_pkg::F3_BNE)
                     st_in = rv32x_pkg::ST_ILLEGAL;
                  else if ((a_val == b_val) == (f3 == rv32x_pkg::F3_BEQ))
                     npc_in = pc_ff + immb;
               end
               rv32x_pkg::OP_JAL: begin
                  wr_in  = 1'b1;
                  val_in = pc4;
                  npc_in = pc_ff + immj;
               end
               rv32x_pkg::OP_LUI: begin
                  wr_in  = 1'b1;
                  val_in = {instr_ff[31:12], 12'd0};
               end
               rv32x_pkg::OP_SYSTEM: begin
                  if (instr_ff != rv32x_pkg::ECALL_WORD) begin
                     st_in = rv32x_pkg::ST_ILLEGAL;
                  end else if (a_val == rv32x_pkg::ECALL_PRINT) begin
                     st_in = rv32x_pkg::ST_PRINT;
                     pv_in = b_val;
                  end else if (a_val == rv32x_pkg::ECALL_EXIT) begin
                     st_in = rv32x_pkg::ST_EXIT;
                  end else begin
                     st_in = rv32x_pkg::ST_BAD_ECALL;
                  end
               end
               default: st_in = rv32x_pkg::ST_ILLEGAL;
            endcase
         end
         rv32x_pkg::S_EXEC: begin
            if (alu_res.done) begin
               if (mem_ff) begin
                  addr_in  = alu_res.value;
                  state_in = rv32x_pkg::S_ADDR;
               end else begin
                  val_in   = alu_res.value;
                  state_in = rv32x_pkg::S_FINISH;
               end
            end
         end
         // range check over every byte of the access
         rv32x_pkg::S_ADDR: begin
            cnt_in  = 2'd0;
            sdat_in = b_val;
            if (end_addr > 33'(MEM_BYTES)) begin
               st_in    = rv32x_pkg::ST_BAD_ADDR;
               state_in = rv32x_pkg::S_FINISH;
            end else if (opc == rv32x_pkg::OP_LOAD) begin
               state_in = rv32x_pkg::S_LD_RD;
            end else begin
               state_in = rv32x_pkg::S_STORE;
            end
         end
         rv32x_pkg::S_LD_RD: begin
            mem_re   = 1'b1;
            state_in = rv32x_pkg::S_LD_CAP;
         end
         rv32x_pkg::S_LD_CAP: begin
            val_in = {mem_q_ff, val_ff[31:8]};
            if (cnt_ff == last_byte) begin
               state_in = rv32x_pkg::S_LD_FIX;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = rv32x_pkg::S_LD_RD;
            end
         end
         // bytes arrive at the top, align and sign extend
         rv32x_pkg::S_LD_FIX: begin
            case (f3)
               rv32x_pkg::F3_BYTE: val_in = {{24{val_ff[31]}}, val_ff[31:24]};
               rv32x_pkg::F3_HALF: val_in = {{16{val_ff[31]}}, val_ff[31:16]};
               default:            val_in = val_ff;
            endcase
            state_in = rv32x_pkg::S_FINISH;
         end
         rv32x_pkg::S_STORE: begin
            mem_we  = 1'b1;
            sdat_in = {8'd0, sdat_ff[31:8]};
            if (cnt_ff == last_byte)
               state_in = rv32x_pkg::S_FINISH;
            else
               cnt_in = cnt_ff + 2'd1;
         end
         // commit architectural state
         rv32x_pkg::S_FINISH: begin
            if (halt_now) begin
               halted_in = 1'b1;
               npc_in    = pc_ff;
               pc_in     = pc_ff;
            end else begin
               pc_in = npc_ff;
            end
            if (wr_ff && !halt_now && rd != rv32x_pkg::REG_ZERO) begin
               rf_we         = 1'b1;
               rf_vld_in[rd] = 1'b1;
            end else begin
               wr_in  = 1'b0;
               val_in = 32'd0;
            end
            state_in = rv32x_pkg::S_RESP;
         end
         rv32x_pkg::S_RESP: begin
            if (rsp_if.ready)
               state_in = rv32x_pkg::S_IDLE;
         end
         default: state_in = rv32x_pkg::S_IDLE;
      endcase
   end

   rv32x_seq_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .opa   (a_val),
      .opb   (alu_b),
      .res   (alu_res)
   );

   // channel outputs
   assign req_if.ready       = (state_ff == rv32x_pkg::S_IDLE);
   assign rsp_if.valid       = (state_ff == rv32x_pkg::S_RESP);
   assign rsp_if.status      = st_ff;
   assign rsp_if.next_pc     = npc_ff;
   assign rsp_if.wb_valid    = wr_ff;
   assign rsp_if.wb_reg      = wr_ff ? rd : rv32x_pkg::REG_ZERO;
   assign rsp_if.wb_value    = val_ff;
   assign rsp_if.print_value = $signed(pv_ff);

   // x0 is never written
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (rf_waddr != rv32x_pkg::REG_ZERO))
      else $error("write to x0");

   // only reset leaves the halted state
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared");

   // no transfer taken during memory clear
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rv32x_pkg::S_CLEAR) |-> !req_if.ready)
      else $error("transfer during clear");

   // result without write-back reports zero register and value
   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.wb_valid) |-> (rsp_if.wb_reg == rv32x_pkg::REG_ZERO
                                               && rsp_if.wb_value == 32'd0))
      else $error("stale write-back fields");

endmodule

`default_nettype wire

### src/rv32x_seq_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rv32x_seq_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rv32x_pkg::alu_ctl_type ctl,
   input  wire logic [31:0]           opa,
   input  wire logic [31:0]           opb,
   output rv32x_pkg::alu_res_type     res
);

   rv32x_pkg::alu_state_type state_ff, state_in;
   rv32x_pkg::alu_op_type    op_ff, op_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] hi_ff, hi_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        carry_ff, carry_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;

   logic        inv, bsel, sum, obit;
   logic [32:0] prod, rem2, diff;
   logic        ge;
   logic [31:0] dsel;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rv32x_pkg::A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      hi_ff    <= hi_in;
      cnt_ff   <= cnt_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   // one bit of the serial adder per cycle
   assign inv  = (op_ff == rv32x_pkg::ALU_SUB) || (op_ff == rv32x_pkg::ALU_SLT);
   assign bsel = b_ff[0] ^ inv;
   assign sum  = a_ff[0] ^ bsel ^ carry_ff;

   // shift-add and restore-divide steps
   assign prod = {1'b0, hi_ff} + (r_ff[0] ? {1'b0, b_ff} : 33'd0);
   assign rem2 = {hi_ff, a_ff[31]};
   assign diff = rem2 - {1'b0, b_ff};
   assign ge   = (rem2 >= {1'b0, b_ff});
   assign dsel = (op_ff == rv32x_pkg::ALU_DIV) ? a_ff : hi_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      obit     = sum;
      case (state_ff)
         rv32x_pkg::A_IDLE: begin
            if (ctl.start) begin
               op_in    = ctl.op;
               a_in     = opa;
               b_in     = opb;
               r_in     = opa;
               hi_in    = 32'd0;
               cnt_in   = 5'd0;
               carry_in = (ctl.op == rv32x_pkg::ALU_SUB) || (ctl.op == rv32x_pkg::ALU_SLT);
               case (ctl.op)
                  rv32x_pkg::ALU_SLL, rv32x_pkg::ALU_SRL, rv32x_pkg::ALU_SRA: begin
                     cnt_in   = opb[4:0];
                     state_in = rv32x_pkg::A_SHF;
                  end
                  rv32x_pkg::ALU_MUL, rv32x_pkg::ALU_MULH: state_in = rv32x_pkg::A_MUL;
                  rv32x_pkg::ALU_DIV, rv32x_pkg::ALU_REM:  state_in = rv32x_pkg::A_DPREP;
                  default: state_in = rv32x_pkg::A_SER;
               endcase
            end
         end
         rv32x_pkg::A_SER: begin
            carry_in = (a_ff[0] & bsel) | (a_ff[0] & carry_ff) | (bsel & carry_ff);
            case (op_ff)
               rv32x_pkg::ALU_XOR: obit = a_ff[0] ^ b_ff[0];
               rv32x_pkg::ALU_OR:  obit = a_ff[0] | b_ff[0];
               rv32x_pkg::ALU_AND: obit = a_ff[0] & b_ff[0];
               default:            obit = sum;
            endcase
            r_in   = {obit, r_ff[31:1]};
            a_in   = {1'b0, a_ff[31:1]};
            b_in   = {1'b0, b_ff[31:1]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               // sign bits are the last ones through
               if (op_ff == rv32x_pkg::ALU_SLT)
                  r_in = {31'd0, (a_ff[0] != b_ff[0]) ? a_ff[0] : sum};
               done_in  = 1'b1;
               state_in = rv32x_pkg::A_IDLE;
            end
         end
         rv32x_pkg::A_SHF: begin
            if (cnt_ff == 5'd0) begin
               done_in  = 1'b1;
               state_in = rv32x_pkg::A_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
               case (op_ff)
                  rv32x_pkg::ALU_SLL: r_in = {r_ff[30:0], 1'b0};
                  rv32x_pkg::ALU_SRL: r_in = {1'b0, r_ff[31:1]};
                  default:            r_in = {r_ff[31], r_ff[31:1]};
               endcase
            end
         end
         rv32x_pkg::A_MUL: begin
            hi_in  = prod[32:1];
            r_in   = {prod[0], r_ff[31:1]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (op_ff == rv32x_pkg::ALU_MUL) begin
                  done_in  = 1'b1;
                  state_in = rv32x_pkg::A_IDLE;
               end else begin
                  state_in = rv32x_pkg::A_MFIX1;
               end
            end
         end
         // signed correction of the high word
         rv32x_pkg::A_MFIX1: begin
            hi_in    = hi_ff - (a_ff[31] ? b_ff : 32'd0);
            state_in = rv32x_pkg::A_MFIX2;
         end
         rv32x_pkg::A_MFIX2: begin
            r_in     = hi_ff - (b_ff[31] ? a_ff : 32'd0);
            done_in  = 1'b1;
            state_in = rv32x_pkg::A_IDLE;
         end
         // divide by zero, else take magnitudes
         rv32x_pkg::A_DPREP: begin
            if (b_ff == 32'd0) begin
               r_in     = (op_ff == rv32x_pkg::ALU_DIV) ? 32'hffff_ffff : a_ff;
               done_in  = 1'b1;
               state_in = rv32x_pkg::A_IDLE;
            end else begin
               a_in     = a_ff[31] ? (32'd0 - a_ff) : a_ff;
               b_in     = b_ff[31] ? (32'd0 - b_ff) : b_ff;
               neg_in   = (op_ff == rv32x_pkg::ALU_DIV) ? (a_ff[31] ^ b_ff[31]) : a_ff[31];
               hi_in    = 32'd0;
               cnt_in   = 5'd0;
               state_in = rv32x_pkg::A_DIV;
            end
         end
         rv32x_pkg::A_DIV: begin
            hi_in  = ge ? diff[31:0] : rem2[31:0];
            a_in   = {a_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31)
               state_in = rv32x_pkg::A_DFIX;
         end
         rv32x_pkg::A_DFIX: begin
            r_in     = neg_ff ? (32'd0 - dsel) : dsel;
            done_in  = 1'b1;
            state_in = rv32x_pkg::A_IDLE;
         end
         default: state_in = rv32x_pkg::A_IDLE;
      endcase
   end

   assign res.done  = done_ff;
   assign res.value = r_ff;

endmodule

`default_nettype wire

### tb/sv/tb_rv32_subset_instruction_executor_unit.sv
`timescale 1ns / 1ps

module tb_rv32_subset_instruction_executor_unit;
   import rv32x_pkg::*;

   localparam int MEM_SIZE = 65536;
   localparam int STALL_LIMIT = 300000;

   typedef struct {
      logic [2:0]         status;
      logic [31:0]        next_pc;
      logic               wb_valid;
      logic [4:0]         wb_reg;
      logic [31:0]        wb_value;
      logic signed [31:0] print_value;
   } exec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rv32x_req_if req ();
   rv32x_rsp_if rsp ();

   rv32_subset_instruction_executor_unit #(.MEM_BYTES(MEM_SIZE)) dut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp)
   );

   // architectural shadow state
   logic [31:0] arch_regs [0:31];
   logic [7:0]  arch_mem [0:MEM_SIZE-1];
   logic [31:0] arch_pc;
   logic        arch_halted;

   exec_result_type pending_results [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  ready_hold = 0;
   bit  idle_on = 1'b0;

   always #4 clock = ~clock;

   // instruction encoders
   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   // execute one instruction on the shadow state
   function automatic exec_result_type execute_instr(logic [31:0] w);
      exec_result_type r;
      logic [6:0]  op, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [31:0] a, b, immi, val, addr, npc;
      logic signed [63:0] prod;
      logic [32:0] span;
      int          len;
      logic        wr;
      op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
      a = arch_regs[w[19:15]];
      b = arch_regs[w[24:20]];
      immi = {{20{w[31]}}, w[31:20]};
      r.status = ST_OK; r.print_value = 0;
      npc = arch_pc + 32'd4; val = 0; wr = 1'b0;
      if (arch_halted) begin
         r.status = ST_EXIT; r.next_pc = arch_pc;
         r.wb_valid = 0; r.wb_reg = 0; r.wb_value = 0;
         return r;
      end
      case (op)
         OP_REG: begin
            wr = 1'b1;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD: val = a + b;
                  F3_SLL: val = a << b[4:0];
                  F3_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  F3_XOR: val = a ^ b;
                  F3_SRL: val = a >> b[4:0];
                  F3_OR:  val = a | b;
                  F3_AND: val = a & b;
                  default: r.status = ST_ILLEGAL;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               val = a - b;
            end else if (f7 == F7_ALT && f3 == F3_SRL) begin
               val = $signed(a) >>> b[4:0];
            end else if (f7 == F7_MULDIV) begin
               prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               case (f3)
                  F3_MUL:  val = prod[31:0];
                  F3_MULH: val = prod[63:32];
                  F3_DIV: begin
                     if (b == 0) val = 32'hffff_ffff;
                     else if (a == 32'h8000_0000 && b == 32'hffff_ffff) val = a;
                     else val = $signed(a) / $signed(b);
                  end
                  F3_REM: begin
                     if (b == 0) val = a;
                     else if (a == 32'h8000_0000 && b == 32'hffff_ffff) val = 0;
                     else val = $signed(a) % $signed(b);
                  end
                  default: r.status = ST_ILLEGAL;
               endcase
            end else begin
               r.status = ST_ILLEGAL;
            end
         end
         OP_IMM: begin
            wr = 1'b1;
            case (f3)
               F3_ADD: val = a + immi;
               F3_SLL: begin
                  if (immi[11:5] != 0) r.status = ST_ILLEGAL;
                  else val = a << immi[4:0];
               end
               F3_SLT: val = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
               F3_XOR: val = a ^ immi;
               F3_SRL: begin
                  if (immi[11:5] == 7'h00) val = a >> immi[4:0];
                  else if (immi[11:5] == F7_ALT) val = $signed(a) >>> immi[4:0];
                  else r.status = ST_ILLEGAL;
               end
               F3_OR:  val = a | immi;
               F3_AND: val = a & immi;
               default: r.status = ST_ILLEGAL;
            endcase
         end
         OP_LOAD: begin
            wr = 1'b1;
            if (f3 > F3_WORD) begin
               r.status = ST_ILLEGAL;
            end else begin
               len = 1 << f3;
               addr = a + immi;
               span = {1'b0, addr} + len;
               if (span > MEM_SIZE) begin
                  r.status = ST_BAD_ADDR;
               end else begin
                  for (int i = 0; i < len; i++) val[8*i +: 8] = arch_mem[addr + i];
                  if (f3 == F3_BYTE) val = {{24{val[7]}}, val[7:0]};
                  if (f3 == F3_HALF) val = {{16{val[15]}}, val[15:0]};
               end
            end
         end
         OP_STORE: begin
            if (f3 > F3_WORD) begin
               r.status = ST_ILLEGAL;
            end else begin
               len = 1 << f3;
               addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
               span = {1'b0, addr} + len;
               if (span > MEM_SIZE) r.status = ST_BAD_ADDR;
               else for (int i = 0; i < len; i++) arch_mem[addr + i] = b[8*i +: 8];
            end
         end
         OP_BRANCH: begin
            if (f3 > F3_BNE) r.status = ST_ILLEGAL;
            else if ((a == b) == (f3 == F3_BEQ))
               npc = arch_pc + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         end
         OP_JAL: begin
            wr = 1'b1;
            val = arch_pc + 32'd4;
            npc = arch_pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         OP_LUI: begin
            wr = 1'b1;
            val = {w[31:12], 12'b0};
         end
         OP_SYSTEM: begin
            if (w != ECALL_WORD) r.status = ST_ILLEGAL;
            else if (arch_regs[REG_A0] == ECALL_PRINT) begin
               r.status = ST_PRINT; r.print_value = arch_regs[REG_A1];
            end else if (arch_regs[REG_A0] == ECALL_EXIT) r.status = ST_EXIT;
            else r.status = ST_BAD_ECALL;
         end
         default: r.status = ST_ILLEGAL;
      endcase
      if (r.status != ST_OK && r.status != ST_PRINT) begin
         arch_halted = 1'b1;
         npc = arch_pc;
         wr = 1'b0;
      end
      if (wr && rd != REG_ZERO) begin
         arch_regs[rd] = val;
      end else begin
         wr = 1'b0; rd = REG_ZERO; val = 0;
      end
      arch_pc = npc;
      r.next_pc = npc; r.wb_valid = wr; r.wb_reg = rd; r.wb_value = val;
      return r;
   endfunction

   // drive one instruction transfer, with optional idle burst ahead of it
   task automatic send_instr(input logic [31:0] w);
      pending_results.push_back(execute_instr(w));
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.instr_word <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // memory access that stays inside the data memory
   function automatic logic [31:0] mem_access(logic is_store);
      logic [4:0]  rs1, rs2, rd;
      logic [2:0]  f3;
      logic [11:0] imm;
      logic [32:0] span;
      rs1 = 5'($urandom); rs2 = 5'($urandom); rd = 5'($urandom);
      f3 = 3'($urandom_range(0, 2));
      imm = 12'($urandom);
      span = {1'b0, arch_regs[rs1] + {{20{imm[11]}}, imm}} + (33'd1 << f3);
      if (span > MEM_SIZE || $urandom_range(0, 2) != 0) begin
         rs1 = REG_ZERO;
         imm = 12'($urandom_range(0, 63));
      end
      if (is_store) return enc_s(imm, rs2, rs1, f3);
      return enc_i(OP_LOAD, imm, rs1, f3, rd);
   endfunction

   // one legal non-halting instruction with random content, or an a0 setup and a print ecall
   task automatic send_random_legal();
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [11:0] imm;
      rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom);
      case ($urandom_range(0, 9))
         0, 1: begin
            case ($urandom_range(0, 8))
               0: begin f3 = F3_ADD; f7 = F7_ALT; end
               1: begin f3 = F3_SRL; f7 = F7_ALT; end
               default: begin
                  f7 = F7_BASE;
                  do f3 = 3'($urandom); while (f3 == 3'd3);
               end
            endcase
            send_instr(enc_r(f7, rs2, rs1, f3, rd));
         end
         2: begin
            case ($urandom_range(0, 3))
               0: f3 = F3_MUL;
               1: f3 = F3_MULH;
               2: f3 = F3_DIV;
               default: f3 = F3_REM;
            endcase
            send_instr(enc_r(F7_MULDIV, rs2, rs1, f3, rd));
         end
         3: begin
            do f3 = 3'($urandom); while (f3 == 3'd3);
            imm = 12'($urandom);
            if (f3 == F3_SLL) imm[11:5] = 7'h00;
            if (f3 == F3_SRL) imm[11:5] = $urandom_range(0, 1) ? F7_ALT : 7'h00;
            send_instr(enc_i(OP_IMM, imm, rs1, f3, rd));
         end
         4: send_instr(mem_access(1'b0));
         5: send_instr(mem_access(1'b1));
         6: begin
            if ($urandom_range(0, 1)) rs2 = rs1;
            send_instr(enc_b(13'($urandom), rs2, rs1, 3'($urandom_range(0, 1))));
         end
         7: send_instr(enc_j(21'($urandom), rd));
         8: send_instr({20'($urandom), rd, OP_LUI});
         default: begin
            send_instr(enc_i(OP_IMM, 12'(ECALL_PRINT), REG_ZERO, F3_ADD, REG_A0));
            send_instr(ECALL_WORD);
         end
      endcase
   endtask

   // corner values for arithmetic, shifts, mulh, div, rem, memory, branches, jal and print
   task automatic test_directed();
      send_instr({20'h80000, 5'd1, OP_LUI});                    // x1 = int min
      send_instr(enc_i(OP_IMM, 12'hfff, REG_ZERO, F3_ADD, 5'd2)); // x2 = -1
      send_instr(enc_i(OP_IMM, 12'h7ff, REG_ZERO, F3_ADD, 5'd3));
      send_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd4));
      send_instr(enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd4));
      send_instr(enc_r(F7_BASE, 5'd2, 5'd3, F3_SLL, 5'd4));
      send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_SLT, 5'd4));
      send_instr(enc_r(F7_ALT, 5'd2, 5'd1, F3_SRL, 5'd4));
      send_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd4));
      send_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd4));  // overflow
      send_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd4));
      send_instr(enc_r(F7_MULDIV, REG_ZERO, 5'd3, F3_DIV, 5'd4)); // divide by zero
      send_instr(enc_r(F7_MULDIV, REG_ZERO, 5'd3, F3_REM, 5'd4));
      send_instr(enc_i(OP_IMM, {F7_ALT, 5'd31}, 5'd1, F3_SRL, 5'd4));
      send_instr(enc_i(OP_IMM, 12'd5, 5'd3, F3_ADD, REG_ZERO)); // write to zero register
      // top of memory, misaligned access
      send_instr({20'h00010, 5'd5, OP_LUI});
      send_instr(enc_s(12'hffc, 5'd1, 5'd5, F3_WORD));
      send_instr(enc_i(OP_LOAD, 12'hffd, 5'd5, F3_HALF, 5'd6));
      send_instr(enc_i(OP_LOAD, 12'hfff, 5'd5, F3_BYTE, 5'd6));
      send_instr(enc_b(13'h1ffc, 5'd2, 5'd2, F3_BEQ));
      send_instr(enc_b(13'h0ffe, 5'd2, 5'd1, F3_BNE));
      send_instr(enc_j(21'h100000, 5'd31));
      send_instr(enc_i(OP_IMM, 12'(ECALL_PRINT), REG_ZERO, F3_ADD, REG_A0));
      send_instr(enc_i(OP_IMM, 12'h800, REG_ZERO, F3_ADD, REG_A1));
      send_instr(ECALL_WORD);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_legal();
   endtask

   // sender holds off until the block has answered everything
   task automatic test_drained_pause();
      @(negedge clock);
      req.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat ($urandom_range(5, 40)) @(negedge clock);
      test_random(20);
   endtask

   // one halting case, then items that the halted block only answers
   task automatic test_halt();
      case ($urandom_range(0, 3))
         0: send_instr({25'($urandom), 7'h0b});
         1: begin
            send_instr(enc_i(OP_IMM, 12'd7, REG_ZERO, F3_ADD, REG_A0));
            send_instr(ECALL_WORD);
         end
         2: begin
            send_instr(enc_i(OP_IMM, 12'(ECALL_EXIT), REG_ZERO, F3_ADD, REG_A0));
            send_instr(ECALL_WORD);
         end
         default: begin
            send_instr({20'h00010, 5'd5, OP_LUI});
            send_instr(enc_i(OP_LOAD, 12'hffe, 5'd5, F3_WORD, 5'd6));
         end
      endcase
      repeat (8) send_instr($urandom);
   endtask

   // result checker
   always @(posedge clock) begin
      exec_result_type e;
      if (rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer, status %0d", rsp.status);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp.status); error_count++;
            end
            if (rsp.next_pc !== e.next_pc) begin
               $error("next_pc exp %h got %h", e.next_pc, rsp.next_pc); error_count++;
            end
            if (rsp.wb_valid !== e.wb_valid) begin
               $error("wb_valid exp %0d got %0d", e.wb_valid, rsp.wb_valid); error_count++;
            end
            if (rsp.wb_reg !== e.wb_reg) begin
               $error("wb_reg exp %0d got %0d", e.wb_reg, rsp.wb_reg); error_count++;
            end
            if (rsp.wb_value !== e.wb_value) begin
               $error("wb_value exp %h got %h", e.wb_value, rsp.wb_value); error_count++;
            end
            if (rsp.print_value !== e.print_value) begin
               $error("print_value exp %0d got %0d", e.print_value, rsp.print_value);
               error_count++;
            end
         end
      end
   end

   // result back-pressure in bursts
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp.ready <= 1'b0;
         ready_hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         ready_hold = $urandom_range(1, 7) - 1;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.instr_word = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < 32; i++) arch_regs[i] = '0;
      for (int i = 0; i < MEM_SIZE; i++) arch_mem[i] = '0;
      arch_pc = '0;
      arch_halted = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      idle_on = 1'b1;
      test_random(600);
      test_drained_pause();
      test_random(300);
      idle_on = 1'b0;
      test_random(200);
      test_halt();
      @(negedge clock);
      req.valid <= 1'b0;

      wait (pending_results.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
